[rtl/pbm_pkg.sv]
// Shared types and constants for the pixel blend block.
// No dependencies; used by the interfaces, lanes, top level and checker.
`timescale 1ns / 1ps

package pbm_pkg;

	localparam int unsigned ChW   = 8;
	localparam int unsigned ModeW = 2;
	localparam int unsigned ProdW = 2 * ChW + 1;
	localparam int unsigned SumW  = ProdW + 1;
	localparam int unsigned QuotW = ChW + 2;

	localparam logic [ChW-1:0]  ChMax   = 8'd255;
	localparam logic [SumW-1:0] RoundUp = 18'd127;

	typedef logic [ChW-1:0] chan_t;

	typedef enum logic [ModeW-1:0] {
		MODE_MUL = 2'd0,
		MODE_SUB = 2'd1,
		MODE_SCR = 2'd2,
		MODE_OVL = 2'd3
	} mode_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} adv_t;

endpackage

[rtl/pbm_if.sv]
// Stream interfaces for the pixel blend block: operand pair in, blended pixel out.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

interface pbm_pix_if;
	logic          valid;
	logic          ready;
	pbm_pkg::chan_t top_red;
	pbm_pkg::chan_t top_green;
	pbm_pkg::chan_t top_blue;
	pbm_pkg::chan_t bottom_red;
	pbm_pkg::chan_t bottom_green;
	pbm_pkg::chan_t bottom_blue;

	modport source (output valid, top_red, top_green, top_blue,
		bottom_red, bottom_green, bottom_blue, input ready);
	modport sink (input valid, top_red, top_green, top_blue,
		bottom_red, bottom_green, bottom_blue, output ready);
endinterface

interface pbm_res_if;
	logic          valid;
	logic          ready;
	pbm_pkg::chan_t out_red;
	pbm_pkg::chan_t out_green;
	pbm_pkg::chan_t out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

[rtl/pbm_lane.sv]
// One channel of the blend datapath: operand select and multiply, divide by 255, finish.
// Depends on pbm_pkg; the top level owns valid bits and the final register.
`timescale 1ns / 1ps

module pbm_lane (
	input  logic           clk,
	input  pbm_pkg::adv_t  adv,
	input  pbm_pkg::mode_t mode,
	input  pbm_pkg::chan_t a,
	input  pbm_pkg::chan_t b,
	output pbm_pkg::chan_t res
);

	pbm_pkg::chan_t                   op_a;
	pbm_pkg::chan_t                   op_b;
	logic                             dbl;
	logic                             inv;
	logic [2*pbm_pkg::ChW-1:0]        prod;
	pbm_pkg::chan_t                   diff;

	logic [pbm_pkg::ProdW-1:0]        x_s1;
	logic                             inv_s1;
	logic                             sub_s1;
	pbm_pkg::chan_t                   diff_s1;

	logic [pbm_pkg::SumW-1:0]         y;
	logic [pbm_pkg::SumW+pbm_pkg::ChW-1:0] y257;

	logic [pbm_pkg::SumW-1:0]         y_s2;
	logic [pbm_pkg::QuotW-1:0]        q0_s2;
	logic                             inv_s2;
	logic                             sub_s2;
	pbm_pkg::chan_t                   diff_s2;

	logic [pbm_pkg::SumW-1:0]         q255;
	logic [pbm_pkg::SumW-1:0]         rem;
	logic [pbm_pkg::QuotW-1:0]        q;

	always_comb begin
		op_a = a;
		op_b = b;
		dbl  = 1'b0;
		inv  = 1'b0;
		case (mode)
			pbm_pkg::MODE_MUL: begin
				op_a = a;
				op_b = b;
			end
			pbm_pkg::MODE_SUB: begin
				op_a = a;
				op_b = b;
			end
			pbm_pkg::MODE_SCR: begin
				op_a = ~a;
				op_b = ~b;
				inv  = 1'b1;
			end
			pbm_pkg::MODE_OVL: begin
				dbl = 1'b1;
				if (a[pbm_pkg::ChW-1]) begin
					op_a = ~a;
					op_b = ~b;
					inv  = 1'b1;
				end
			end
			default: begin
				op_a = a;
				op_b = b;
			end
		endcase
	end

	assign prod = op_a * op_b;
	assign diff = (a > b) ? (a - b) : '0;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			x_s1    <= dbl ? {prod, 1'b0} : {1'b0, prod};
			inv_s1  <= inv;
			sub_s1  <= (mode == pbm_pkg::MODE_SUB);
			diff_s1 <= diff;
		end
	end

	// floor(y/255) estimate via y*257/2^16; low by at most one
	assign y    = {1'b0, x_s1} + pbm_pkg::RoundUp;
	assign y257 = {y, {pbm_pkg::ChW{1'b0}}} + {{pbm_pkg::ChW{1'b0}}, y};

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			y_s2    <= y;
			q0_s2   <= y257[pbm_pkg::SumW+pbm_pkg::ChW-1 -: pbm_pkg::QuotW];
			inv_s2  <= inv_s1;
			sub_s2  <= sub_s1;
			diff_s2 <= diff_s1;
		end
	end

	assign q255 = {q0_s2, {pbm_pkg::ChW{1'b0}}} - {{pbm_pkg::ChW{1'b0}}, q0_s2};
	assign rem  = y_s2 - q255;
	assign q    = (rem >= {{(pbm_pkg::SumW-pbm_pkg::ChW){1'b0}}, pbm_pkg::ChMax})
		? q0_s2 + 1'b1 : q0_s2;

	always_comb begin
		if (sub_s2) begin
			res = diff_s2;
		end else if (inv_s2) begin
			res = ~q[pbm_pkg::ChW-1:0];
		end else begin
			res = q[pbm_pkg::ChW-1:0];
		end
	end

endmodule

[rtl/pixel_blend_modes.sv]
// Top level of the pixel blend block: mode register, three channel lanes, output merge.
// Depends on pbm_pkg, pbm_if (pbm_pix_if, pbm_res_if) and pbm_lane.
//
//   port     dir  kind          contents
//   pix      in   valid/ready   top and bottom RGB pixel pair
//   blend    out  valid/ready   blended RGB pixel
//   cfg_*    in   write only    blend_mode (2 bits)
//
// One pixel per clock sustained while blend.ready is held high; a transfer in passes
// through v_s1 and v_s2 into out_valid_q, and the result transfers while blend.ready is high.
// Stages: multiply, divide by 255, finish into the output register.
// Each stage advances when the one after it is empty or moving, so bubbles collapse.
// arst_n clears the valid bits and the mode (multiply); payload registers are not reset.
`timescale 1ns / 1ps

module pixel_blend_modes (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pbm_pkg::ModeW-1:0]  cfg_wdata,
	pbm_pix_if.sink                    pix,
	pbm_res_if.source                  blend
);

	pbm_pkg::mode_t mode_q;
	pbm_pkg::adv_t  adv;
	logic           adv_out;
	logic           v_s1;
	logic           v_s2;
	logic           out_valid_q;
	pbm_pkg::chan_t res_red;
	pbm_pkg::chan_t res_green;
	pbm_pkg::chan_t res_blue;
	pbm_pkg::chan_t red_q;
	pbm_pkg::chan_t green_q;
	pbm_pkg::chan_t blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pbm_pkg::MODE_MUL;
		end else if (cfg_we) begin
			mode_q <= pbm_pkg::mode_t'(cfg_wdata);
		end
	end

	assign adv_out = !out_valid_q || blend.ready;
	assign adv.s2  = !v_s2 || adv_out;
	assign adv.s1  = !v_s1 || adv.s2;

	assign pix.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= pix.valid;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	pbm_lane u_lane_red (
		.clk  (clk),
		.adv  (adv),
		.mode (mode_q),
		.a    (pix.top_red),
		.b    (pix.bottom_red),
		.res  (res_red)
	);

	pbm_lane u_lane_green (
		.clk  (clk),
		.adv  (adv),
		.mode (mode_q),
		.a    (pix.top_green),
		.b    (pix.bottom_green),
		.res  (res_green)
	);

	pbm_lane u_lane_blue (
		.clk  (clk),
		.adv  (adv),
		.mode (mode_q),
		.a    (pix.top_blue),
		.b    (pix.bottom_blue),
		.res  (res_blue)
	);

	always_ff @(posedge clk) begin
		if (adv_out) begin
			red_q   <= res_red;
			green_q <= res_green;
			blue_q  <= res_blue;
		end
	end

	assign blend.valid     = out_valid_q;
	assign blend.out_red   = red_q;
	assign blend.out_green = green_q;
	assign blend.out_blue  = blue_q;

endmodule

[rtl/pbm_chk.sv]
// Port-level checker for pixel_blend_modes, attached by the bind at the end of this file.
// Depends on pbm_pkg and the top level's ports only.
`timescale 1ns / 1ps

module pbm_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input pbm_pkg::chan_t out_red,
	input pbm_pkg::chan_t out_green,
	input pbm_pkg::chan_t out_blue
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("result changed or dropped while stalled");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output side is ready");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing three cycles after transfer");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer ##1 !in_xfer ##1 !in_xfer && out_ready ##1 1'b1 |-> !out_valid
			|| !$past(out_ready, 1) || !$past(out_ready, 2) || !$past(out_ready, 3)
			|| $past(out_valid, 1) && !$past(out_ready, 1))
		else $error("result appeared with no transfer in");

endmodule

bind pixel_blend_modes pbm_chk u_pbm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix.valid),
	.in_ready  (pix.ready),
	.out_valid (blend.valid),
	.out_ready (blend.ready),
	.out_red   (blend.out_red),
	.out_green (blend.out_green),
	.out_blue  (blend.out_blue)
);
